// ===== hdl/cdtb_pkg.sv =====
// Shared types, constants and helpers for the character display text buffer.
// Used by cdtb_cell_mem, cdtb_cursor and char_display_text_buffer.
// No dependencies.
package cdtb_pkg;

    // Default number of columns per row
    localparam int COLUMNS_DEF = 16;

    // Fixed field widths of the command and result beats
    localparam int KIND_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int TROW_W     = 2;
    localparam int TCOL_W     = 5;
    localparam int OUT_COL_W  = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Character that an empty cell holds
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    // Command codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT_IF_SPACE = 4'd0,
        KIND_PUT          = 4'd1,
        KIND_CLEAR        = 4'd2,
        KIND_CLEAR_AFTER  = 4'd3,
        KIND_UP           = 4'd4,
        KIND_DOWN         = 4'd5,
        KIND_RIGHT        = 4'd6,
        KIND_LEFT         = 4'd7,
        KIND_SET          = 4'd8,
        KIND_READ         = 4'd9
    } kind_t;

    // Latched command handed to the cursor unit
    typedef struct packed {
        kind_t             kind;
        logic [TROW_W-1:0] trow;
        logic [TCOL_W-1:0] tcol;
    } cmd_t;

    // Per-cycle operation on the cell memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
        logic clr_after;
    } mem_op_t;

    // Target position lies on the display
    function automatic logic pos_valid(
        input logic [TROW_W-1:0] row,
        input logic [TCOL_W-1:0] col,
        input int                cols
    );
        logic [7:0] col_ext;
        logic [7:0] cols_ext;
        col_ext  = 8'(col);
        cols_ext = 8'(cols);
        return (row[1] == 1'b0) && (col_ext < cols_ext);
    endfunction

endpackage

// ===== hdl/cdtb_cell_mem.sv =====
// Character cell memory: synchronous RAM with registered read,
// plus per-cell valid bits so that clears take effect at once.
// Depends on cdtb_pkg.
module cdtb_cell_mem #(
    parameter int CELLS  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cdtb_pkg::mem_op_t       op,
    input  logic [ADDR_W-1:0]       rd_addr,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [cdtb_pkg::CHAR_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]       clr_from,
    output logic [cdtb_pkg::CHAR_W-1:0] rd_char
);
    import cdtb_pkg::*;

    logic [CHAR_W-1:0] mem [CELLS];
    logic [CELLS-1:0]  valid_reg;
    logic [CELLS-1:0]  keep_mask;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // Keep cells up to and including the cursor on a clear-after
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            keep_mask[i] = (ADDR_W'(i) <= clr_from);
        end
    end

    // Write the character array
    always_ff @(posedge clk)
    begin
        if (op.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of data and valid bit
    always_ff @(posedge clk)
    begin
        if (op.rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Track written cells; clears drop valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (op.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (op.clr_after)
            begin
                valid_reg <= valid_reg & keep_mask;
            end
            else if (op.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An unwritten cell reads as a space
    assign rd_char = rd_valid_reg ? rd_data_reg : SPACE_CHAR;

endmodule

// ===== hdl/cdtb_cursor.sv =====
// Cursor unit: holds cursor row, column and the space flag, and works out
// the command status and the next cursor state. Depends on cdtb_pkg.
module cdtb_cursor #(
    parameter int COLUMNS = 16,
    parameter int COL_W   = 4,
    parameter int ADDR_W  = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cdtb_pkg::cmd_t     cmd,
    input  logic               cell_space,
    input  logic               commit,
    output logic               row,
    output logic [COL_W-1:0]   col,
    output logic               space_flag,
    output logic [ADDR_W-1:0]  here_addr,
    output logic               ok,
    output logic               row_next,
    output logic [COL_W-1:0]   col_next,
    output logic               flag_next
);
    import cdtb_pkg::*;

    localparam int EXT_W = COL_W + TCOL_W;
    localparam logic [COL_W-1:0] LAST = COL_W'(COLUMNS - 1);

    logic             row_reg;
    logic [COL_W-1:0] col_reg;
    logic             flag_reg;
    logic             at_last;
    logic             at_end0;
    logic             pre_last;
    logic             adv_row;
    logic [COL_W-1:0] adv_col;
    logic             adv_flag;
    logic [EXT_W-1:0] tcol_ext;
    logic             tvalid;

    assign at_last  = row_reg && (col_reg == LAST);
    assign at_end0  = !row_reg && (col_reg == LAST);
    assign pre_last = row_reg && (col_reg == LAST - COL_W'(1));
    assign tcol_ext = EXT_W'(cmd.tcol);
    assign tvalid   = pos_valid(cmd.trow, cmd.tcol, COLUMNS);

    // Cursor after a write
    always_comb
    begin
        adv_row  = row_reg;
        adv_col  = col_reg;
        adv_flag = 1'b1;
        priority if (at_last)
        begin
            adv_flag = 1'b0;
        end
        else if (pre_last)
        begin
            adv_col  = LAST;
            adv_flag = 1'b0;
        end
        else if (at_end0)
        begin
            adv_row = 1'b1;
            adv_col = '0;
        end
        else
        begin
            adv_col = col_reg + COL_W'(1);
        end
    end

    // Next cursor state and status per command
    always_comb
    begin
        ok        = 1'b0;
        row_next  = row_reg;
        col_next  = col_reg;
        flag_next = flag_reg;
        unique case (cmd.kind)
            KIND_PUT_IF_SPACE:
            begin
                if (cell_space)
                begin
                    ok        = 1'b1;
                    row_next  = adv_row;
                    col_next  = adv_col;
                    flag_next = adv_flag;
                end
            end
            KIND_PUT:
            begin
                ok        = 1'b1;
                row_next  = adv_row;
                col_next  = adv_col;
                flag_next = adv_flag;
            end
            KIND_CLEAR:
            begin
                ok        = 1'b1;
                row_next  = 1'b0;
                col_next  = '0;
                flag_next = 1'b1;
            end
            KIND_CLEAR_AFTER:
            begin
                ok = 1'b1;
            end
            KIND_UP:
            begin
                if (row_reg)
                begin
                    ok       = 1'b1;
                    row_next = 1'b0;
                end
            end
            KIND_DOWN:
            begin
                if (!row_reg)
                begin
                    ok       = 1'b1;
                    row_next = 1'b1;
                end
            end
            KIND_RIGHT:
            begin
                if (at_end0)
                begin
                    ok       = 1'b1;
                    row_next = 1'b1;
                    col_next = '0;
                end
                else if (!at_last)
                begin
                    ok       = 1'b1;
                    col_next = col_reg + COL_W'(1);
                end
            end
            KIND_LEFT:
            begin
                if (row_reg && (col_reg == '0))
                begin
                    ok       = 1'b1;
                    row_next = 1'b0;
                    col_next = LAST;
                end
                else if (col_reg != '0)
                begin
                    ok       = 1'b1;
                    col_next = col_reg - COL_W'(1);
                end
            end
            KIND_SET:
            begin
                if (tvalid)
                begin
                    ok       = 1'b1;
                    row_next = cmd.trow[0];
                    col_next = tcol_ext[COL_W-1:0];
                end
            end
            KIND_READ:
            begin
                ok = tvalid;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Hold cursor state; update on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 1'b0;
            col_reg  <= '0;
            flag_reg <= 1'b1;
        end
        else if (commit)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            flag_reg <= flag_next;
        end
    end

    assign row        = row_reg;
    assign col        = col_reg;
    assign space_flag = flag_reg;
    assign here_addr  = row_reg ? (ADDR_W'(COLUMNS) + ADDR_W'(col_reg)) : ADDR_W'(col_reg);

endmodule

// ===== hdl/char_display_text_buffer.sv =====
// Two-row character display buffer: top level with command sequencing.
// Depends on cdtb_pkg, cdtb_cell_mem and cdtb_cursor.
//
// Usage:
//   Commands enter on the s_ side, one beat per command; every command
//   gives exactly one result beat on the m_ side (status, read character,
//   cursor position and space flag after the command).
//   Each command passes through an accept cycle and an evaluate state: the
//   accept cycle issues the cell memory read (cell under the cursor, or the
//   target cell for a read), and the evaluate state (ST_EXEC) evaluates the
//   command, writes the cell memory, updates the cursor and loads the result
//   register. The registered read of the cell memory sets this split; a new
//   command is accepted only after the previous one has been evaluated, and
//   its result beat is valid once the result register is loaded.
//   Clears take effect at once through per-cell valid bits; there is no
//   clearing pass.
//   Reset: all cells read as spaces, cursor at row 0 column 0, space flag
//   set, no result pending.
//   Stall: a waiting result does not block acceptance of the next command;
//   that command waits in its evaluate cycle until the result register is
//   taken.
module char_display_text_buffer #(
    parameter int COLUMNS = cdtb_pkg::COLUMNS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // kind[3:0], char_code[11:4], target_row[13:12], target_column[18:14]
    input  logic [cdtb_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ok[0], read_char[8:1], cursor_row[9], cursor_column[13:10],
    // space_left[14]
    output logic [cdtb_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import cdtb_pkg::*;

    localparam int CELLS  = 2 * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int EXT_W  = COL_W + TCOL_W;
    localparam int OEXT_W = COL_W + OUT_COL_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    cmd_t                  in_cmd;
    logic [CHAR_W-1:0]     in_char;
    logic                  accept;
    logic                  fire;
    logic [EXT_W-1:0]      in_tcol_ext;
    logic [ADDR_W-1:0]     target_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     here_addr;
    mem_op_t               op;
    logic [CHAR_W-1:0]     rd_char;
    logic                  cell_space;
    logic                  cur_row;
    logic [COL_W-1:0]      cur_col;
    logic                  cur_flag;
    logic                  ok;
    logic                  row_next;
    logic [COL_W-1:0]      col_next;
    logic                  flag_next;
    logic [CHAR_W-1:0]     read_char;
    logic [OEXT_W-1:0]     col_out_ext;

    // Unpack the command beat
    assign in_cmd.kind = kind_t'(s_tdata[3:0]);
    assign in_char     = s_tdata[11:4];
    assign in_cmd.trow = s_tdata[13:12];
    assign in_cmd.tcol = s_tdata[18:14];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    // Read address: target cell for a read, cell under the cursor otherwise
    assign in_tcol_ext = EXT_W'(in_cmd.tcol);
    assign target_addr = in_cmd.trow[0]
                       ? (ADDR_W'(COLUMNS) + ADDR_W'(in_tcol_ext[COL_W-1:0]))
                       : ADDR_W'(in_tcol_ext[COL_W-1:0]);
    assign rd_addr     = (in_cmd.kind == KIND_READ) ? target_addr : here_addr;

    // Memory operation for this cycle
    assign cell_space   = (rd_char == SPACE_CHAR);
    assign op.rd_en     = accept;
    assign op.wr_en     = fire && ((cmd_reg.kind == KIND_PUT) ||
                                   ((cmd_reg.kind == KIND_PUT_IF_SPACE) && cell_space));
    assign op.clr_all   = fire && (cmd_reg.kind == KIND_CLEAR);
    assign op.clr_after = fire && (cmd_reg.kind == KIND_CLEAR_AFTER);

    cdtb_cell_mem #(
        .CELLS  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .rd_addr  (rd_addr),
        .wr_addr  (here_addr),
        .wr_data  (char_reg),
        .clr_from (here_addr),
        .rd_char  (rd_char)
    );

    cdtb_cursor #(
        .COLUMNS (COLUMNS),
        .COL_W   (COL_W),
        .ADDR_W  (ADDR_W)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_reg),
        .cell_space (cell_space),
        .commit     (fire),
        .row        (cur_row),
        .col        (cur_col),
        .space_flag (cur_flag),
        .here_addr  (here_addr),
        .ok         (ok),
        .row_next   (row_next),
        .col_next   (col_next),
        .flag_next  (flag_next)
    );

    // Result fields
    assign read_char   = ((cmd_reg.kind == KIND_READ) && ok) ? rd_char : '0;
    assign col_out_ext = OEXT_W'(col_next);

    // Latch the command on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            char_reg <= in_char;
        end
    end

    // Sequence commands and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_DATA_W'({flag_next,
                                                     col_out_ext[OUT_COL_W-1:0],
                                                     row_next, read_char, ok});
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An accepted command enters the evaluate state in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted command not evaluated");

    // Evaluating a command always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("result lost after evaluation");

    // Cursor column stays on the display
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_col) < COLUMNS))
        else $error("cursor column out of range");

    // Cursor state moves only when a command is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(cur_row) && $stable(cur_col) && $stable(cur_flag)))
        else $error("cursor changed without a command");

endmodule
